>>> rtl/ousnc_pkg.sv
package ousnc_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // long divider for dt/tau
    localparam int DIV_NUM_W = 41;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = 6;

    // integer square root
    localparam int SQRT_IN_W  = 63;
    localparam int SQRT_OUT_W = 32;
    localparam int SQRT_CNT_W = 5;

    // operation codes
    localparam logic [2:0] OP_EULER = 3'd0;
    localparam logic [2:0] OP_RK0   = 3'd1;
    localparam logic [2:0] OP_RK1   = 3'd2;
    localparam logic [2:0] OP_RK2   = 3'd3;
    localparam logic [2:0] OP_RK3   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_REVERSAL_V      = 3'd0;
    localparam logic [2:0] REG_TAU_US          = 3'd1;
    localparam logic [2:0] REG_G_MEAN          = 3'd2;
    localparam logic [2:0] REG_G_STD           = 3'd3;
    localparam logic [2:0] REG_ACTIVE_SETTLING = 3'd4;
    localparam logic [2:0] REG_IGNORE_NEGATIVE = 3'd5;

    // floor(2^32 / k) for the series term divisors
    function automatic logic [32:0] recip(input logic [2:0] k);
        logic [32:0] r;
        case (k)
            3'd1:    r = 33'h1_0000_0000;
            3'd2:    r = 33'h0_8000_0000;
            3'd3:    r = 33'h0_5555_5555;
            3'd4:    r = 33'h0_4000_0000;
            3'd5:    r = 33'h0_3333_3333;
            3'd6:    r = 33'h0_2AAA_AAAA;
            3'd7:    r = 33'h0_2492_4924;
            default: r = 33'h0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/ousnc_mul.sv
module ousnc_mul (
    input  logic                                 aclk,
    input  logic signed [ousnc_pkg::MUL_W-1:0]   op_a,
    input  logic signed [ousnc_pkg::MUL_W-1:0]   op_b,
    output logic signed [ousnc_pkg::PROD_W-1:0]  prod
);

    logic signed [ousnc_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= ousnc_pkg::PROD_W'(op_a) * ousnc_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

>>> rtl/ousnc_div.sv
module ousnc_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [ousnc_pkg::DIV_NUM_W-1:0]      num,
    input  logic [ousnc_pkg::DIV_DEN_W-1:0]      den,
    output logic                                 done,
    output logic [ousnc_pkg::DIV_NUM_W-1:0]      quot
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [ousnc_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [ousnc_pkg::DIV_NUM_W-1:0]     shf_reg;
    logic [ousnc_pkg::DIV_DEN_W-1:0]     rem_reg;
    logic [ousnc_pkg::DIV_DEN_W-1:0]     den_reg;

    logic [ousnc_pkg::DIV_DEN_W:0]       trial;
    logic                                ge;
    logic [ousnc_pkg::DIV_DEN_W-1:0]     rem_next;
    logic [ousnc_pkg::DIV_NUM_W-1:0]     shf_next;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    always_comb begin
        trial    = {rem_reg, shf_reg[ousnc_pkg::DIV_NUM_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? ousnc_pkg::DIV_DEN_W'(trial - {1'b0, den_reg})
                      : trial[ousnc_pkg::DIV_DEN_W-1:0];
        shf_next = {shf_reg[ousnc_pkg::DIV_NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                shf_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                shf_reg <= shf_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ousnc_pkg::DIV_CNT_W'(ousnc_pkg::DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = shf_reg;

endmodule

>>> rtl/ousnc_sqrt.sv
module ousnc_sqrt (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [ousnc_pkg::SQRT_IN_W-1:0]      val,
    output logic                                 done,
    output logic [ousnc_pkg::SQRT_OUT_W-1:0]     root
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [ousnc_pkg::SQRT_CNT_W-1:0]    cnt_reg;
    logic [63:0]                         v_reg;
    logic [63:0]                         r_reg;
    logic [63:0]                         bit_reg;

    logic [63:0] sum;
    logic        ge;

    // two radicand bits per cycle
    always_comb begin
        sum = r_reg + bit_reg;
        ge  = v_reg >= sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                v_reg    <= {1'b0, val};
                r_reg    <= '0;
                bit_reg  <= 64'd1 << 62;
            end else if (busy_reg) begin
                if (ge) begin
                    v_reg <= v_reg - sum;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[ousnc_pkg::SQRT_OUT_W-1:0];

endmodule

>>> rtl/ou_synaptic_noise_conductance_core.sv
// channel  | direction | handshake            | payload
// cfg      | in        | cfg_valid/cfg_ready  | cfg_addr register index, cfg_data value
// s_       | in        | s_tvalid/s_tready    | s_tdata step fields, s_tuser op
// m_       | out       | m_tvalid/m_tready    | m_tdata conductance and current, m_tuser flag
//
// euler and rk substep 0, from accept to m_tvalid, multiplies all on one shared multiplier:
// decode, long divide for dt/tau, 7 series terms, 8 squarings, square root,
// decay, noise and current; dt/tau of 32 or more skips series and squarings
// hold, average, commit and disabled steps skip to S_CUR; a new item is taken only when idle
// aresetn is synchronous and restores the register reset values and zero state
// a stalled m_ side holds the finished item; cfg writes are always taken
module ou_synaptic_noise_conductance_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    // input step transfers
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // dt_us, membrane_v, gauss_sample, settling, enabled
    input  logic [2:0]  s_tuser,   // op
    // result transfers
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // conductance, current_add
    output logic [0:0]  m_tuser    // current_valid
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_DIV, S_T_MUL, S_T_REC, S_T_Q, S_T_FIX, S_A0,
        S_SQR, S_SQR_W, S_AA, S_ROOT, S_ROOT_W, S_DECAY, S_S, S_N, S_SUM,
        S_CUR, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [15:0] reversal_reg;
    logic [23:0]        tau_reg;
    logic signed [31:0] gmean_reg;
    logic [30:0]        gstd_reg;
    logic               act_settle_reg;
    logic               ign_neg_reg;

    // captured step fields
    logic [2:0]         op_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] vm_reg;
    logic signed [15:0] gn_reg;
    logic               settle_reg;
    logic               en_reg;

    // model state
    logic signed [31:0] cond_now_reg;
    logic signed [31:0] cond_pred_reg;

    // working registers
    logic [28:0]        x_reg;
    logic [32:0]        term_reg;
    logic [29:0]        tv_reg;
    logic [29:0]        q0_reg;
    logic [32:0]        e_reg;
    logic [2:0]         k_reg;
    logic [31:0]        a_reg;
    logic [2:0]         sq_cnt_reg;
    logic [31:0]        b_reg;
    logic signed [33:0] decay_reg;

    // output register
    logic               m_tvalid_reg;
    logic signed [31:0] out_cond_reg;
    logic signed [31:0] out_cur_reg;
    logic               out_valid_reg;

    // shared multiplier
    logic signed [ousnc_pkg::MUL_W-1:0]  mul_a;
    logic signed [ousnc_pkg::MUL_W-1:0]  mul_b;
    logic signed [ousnc_pkg::PROD_W-1:0] prod;

    // divider and root
    logic                                 div_start;
    logic [16:0]                          dt_eff;
    logic [ousnc_pkg::DIV_NUM_W-1:0]      div_num;
    logic [ousnc_pkg::DIV_DEN_W-1:0]      div_den;
    logic                                 div_done;
    logic [ousnc_pkg::DIV_NUM_W-1:0]      div_quot;
    logic                                 sqrt_start;
    logic [ousnc_pkg::SQRT_IN_W-1:0]      sqrt_val;
    logic                                 sqrt_done;
    logic [ousnc_pkg::SQRT_OUT_W-1:0]     sqrt_root;

    // combinational helpers
    logic signed [16:0] v_diff;
    logic signed [32:0] g_dev;
    logic [29:0]        rem_t;
    logic [29:0]        term_new;
    logic [32:0]        e_next;
    logic signed [35:0] noise;
    logic signed [36:0] g_sum;
    logic signed [31:0] g_new;
    logic signed [32:0] avg_sum;
    logic               cur_ok;
    logic signed [31:0] cur_val;
    logic               out_free;

    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        logic signed [31:0] r;
        if (v[43:31] == {13{v[43]}}) begin
            r = v[31:0];
        end else begin
            r = v[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {out_cur_reg, out_cond_reg};
    assign m_tuser   = out_valid_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // dt doubled on rk substep 0, tau of zero read as one
    assign dt_eff    = (op_reg == ousnc_pkg::OP_RK0) ? {dt_reg, 1'b0} : {1'b0, dt_reg};
    assign div_num   = {dt_eff, 24'd0};
    assign div_den   = (tau_reg == '0) ? 24'd1 : tau_reg;
    assign div_start = (state_reg == S_DECODE) && en_reg &&
                       (op_reg == ousnc_pkg::OP_EULER || op_reg == ousnc_pkg::OP_RK0);

    // 1 - a^2 in Q2.62
    assign sqrt_start = (state_reg == S_ROOT);
    assign sqrt_val   = ousnc_pkg::SQRT_IN_W'((64'd1 << 62) - 64'(prod));

    always_comb begin
        v_diff   = 17'(reversal_reg) - 17'(vm_reg);
        g_dev    = 33'(cond_now_reg) - 33'(gmean_reg);
        // term correction: the reciprocal estimate is at most one low
        rem_t    = tv_reg - prod[29:0];
        term_new = (rem_t >= {27'd0, k_reg}) ? q0_reg + 30'd1 : q0_reg;
        e_next   = k_reg[0] ? e_reg - {3'd0, term_new} : e_reg + {3'd0, term_new};
        noise    = 36'(prod >>> 12);
        g_sum    = 37'(gmean_reg) + 37'(decay_reg) + 37'(noise);
        g_new    = sat32(44'(g_sum));
        avg_sum  = 33'(cond_now_reg) + 33'(cond_pred_reg);
        cur_ok   = en_reg && (!ign_neg_reg || cond_now_reg > 32'sd0) &&
                   (!settle_reg || act_settle_reg);
        cur_val  = cur_ok ? sat32(44'(prod >>> 6)) : 32'sd0;
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_T_MUL: begin
                mul_a = $signed({1'b0, term_reg});
                mul_b = $signed({5'd0, x_reg});
            end
            S_T_REC: begin
                mul_a = $signed({4'd0, prod[61:32]});
                mul_b = $signed({1'b0, ousnc_pkg::recip(k_reg)});
            end
            S_T_Q: begin
                mul_a = $signed({4'd0, prod[61:32]});
                mul_b = $signed({31'd0, k_reg});
            end
            S_SQR, S_AA: begin
                mul_a = $signed({2'd0, a_reg});
                mul_b = $signed({2'd0, a_reg});
            end
            S_DECAY: begin
                mul_a = 34'(g_dev);
                mul_b = $signed({2'd0, a_reg});
            end
            S_S: begin
                mul_a = $signed({3'd0, gstd_reg});
                mul_b = $signed({2'd0, b_reg});
            end
            S_N: begin
                mul_a = $signed({3'd0, prod[61:31]});
                mul_b = 34'(gn_reg);
            end
            S_CUR, S_OUT: begin
                mul_a = 34'(cond_now_reg);
                mul_b = 34'(v_diff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ousnc_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    ousnc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    ousnc_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .val     (sqrt_val),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            reversal_reg   <= '0;
            tau_reg        <= 24'd1000;
            gmean_reg      <= '0;
            gstd_reg       <= '0;
            act_settle_reg <= 1'b0;
            ign_neg_reg    <= 1'b0;
            cond_now_reg   <= '0;
            cond_pred_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // register writes
            if (cfg_valid) begin
                unique case (cfg_addr)
                    ousnc_pkg::REG_REVERSAL_V:      reversal_reg   <= cfg_data[15:0];
                    ousnc_pkg::REG_TAU_US:          tau_reg        <= cfg_data[23:0];
                    ousnc_pkg::REG_G_MEAN:          gmean_reg      <= cfg_data;
                    ousnc_pkg::REG_G_STD:           gstd_reg       <= cfg_data[30:0];
                    ousnc_pkg::REG_ACTIVE_SETTLING: act_settle_reg <= cfg_data[0];
                    ousnc_pkg::REG_IGNORE_NEGATIVE: ign_neg_reg    <= cfg_data[0];
                    default: ;
                endcase
            end

            // new result loaded, or the held one taken downstream
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= s_tuser;
                        dt_reg     <= s_tdata[15:0];
                        vm_reg     <= s_tdata[31:16];
                        gn_reg     <= s_tdata[47:32];
                        settle_reg <= s_tdata[48];
                        en_reg     <= s_tdata[49];
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (!en_reg) begin
                        cond_now_reg <= '0;
                        state_reg    <= S_CUR;
                    end else begin
                        case (op_reg)
                            ousnc_pkg::OP_EULER, ousnc_pkg::OP_RK0: state_reg <= S_DIV;
                            ousnc_pkg::OP_RK1: begin
                                cond_now_reg <= avg_sum[32:1];
                                state_reg    <= S_CUR;
                            end
                            ousnc_pkg::OP_RK3: begin
                                cond_now_reg <= cond_pred_reg;
                                state_reg    <= S_CUR;
                            end
                            default: state_reg <= S_CUR;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        // dt/tau of 32 or more decays fully
                        if (|div_quot[40:29]) begin
                            a_reg     <= '0;
                            state_reg <= S_AA;
                        end else begin
                            x_reg     <= div_quot[28:0];
                            term_reg  <= 33'h1_0000_0000;
                            e_reg     <= 33'h1_0000_0000;
                            k_reg     <= 3'd1;
                            state_reg <= S_T_MUL;
                        end
                    end
                end
                S_T_MUL: state_reg <= S_T_REC;
                S_T_REC: begin
                    tv_reg    <= prod[61:32];
                    state_reg <= S_T_Q;
                end
                S_T_Q: begin
                    q0_reg    <= prod[61:32];
                    state_reg <= S_T_FIX;
                end
                S_T_FIX: begin
                    term_reg <= {3'd0, term_new};
                    e_reg    <= e_next;
                    if (k_reg == 3'd7) begin
                        state_reg <= S_A0;
                    end else begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= S_T_MUL;
                    end
                end
                S_A0: begin
                    a_reg      <= 32'((34'(e_reg) + 34'd1) >> 1);
                    sq_cnt_reg <= '0;
                    state_reg  <= S_SQR;
                end
                S_SQR: state_reg <= S_SQR_W;
                S_SQR_W: begin
                    // exp(-t/256) raised to the 256th power
                    a_reg      <= 32'((64'(prod) + (64'd1 << 30)) >> 31);
                    sq_cnt_reg <= sq_cnt_reg + 3'd1;
                    state_reg  <= (sq_cnt_reg == 3'd7) ? S_AA : S_SQR;
                end
                S_AA:   state_reg <= S_ROOT;
                S_ROOT: state_reg <= S_ROOT_W;
                S_ROOT_W: begin
                    if (sqrt_done) begin
                        b_reg     <= sqrt_root;
                        state_reg <= S_DECAY;
                    end
                end
                S_DECAY: state_reg <= S_S;
                S_S: begin
                    decay_reg <= 34'(prod >>> 31);
                    state_reg <= S_N;
                end
                S_N: state_reg <= S_SUM;
                S_SUM: begin
                    if (op_reg == ousnc_pkg::OP_EULER) begin
                        cond_now_reg <= g_new;
                    end else begin
                        cond_pred_reg <= g_new;
                    end
                    state_reg <= S_CUR;
                end
                S_CUR: state_reg <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        out_cond_reg  <= cond_now_reg;
                        out_cur_reg   <= cur_val;
                        out_valid_reg <= cur_ok;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> bench/ou_synaptic_noise_conductance_checker.sv
module ou_synaptic_noise_conductance_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // dt_us, membrane_v, gauss_sample, settling, enabled
    input  logic [2:0]  s_tuser,   // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // conductance, current_add
    input  logic [0:0]  m_tuser,   // current_valid
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] conductance;
        logic [31:0] current_add;
        logic        current_valid;
    } step_result_t;

    step_result_t expected_steps[$];

    longint          rev_mv;
    longint unsigned tau_cfg;
    longint          g0;
    longint unsigned g_sd;
    logic            inject_settling;
    logic            skip_negative;
    longint          g_now;
    longint          g_pred;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // exp(-dt/tau) in q1.31: taylor series on dt/tau/256, then squared 8 times
    function automatic longint unsigned exp_decay(input longint unsigned dt);
        longint unsigned tau;
        longint unsigned x;
        longint unsigned term;
        longint unsigned e;
        longint unsigned a;
        tau = (tau_cfg == 0) ? 64'd1 : tau_cfg;
        x = (dt << 24) / tau;
        if (x >= (64'd1 << 29)) return 0;
        term = 64'd1 << 32;
        e = term;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x) >> 32) / k;
            if (k % 2 == 1) e = e - term;
            else e = e + term;
        end
        a = (e + 1) >> 1;
        repeat (8) a = (a * a + (64'd1 << 30)) >> 31;
        return a;
    endfunction

    function automatic longint ou_advance(input longint unsigned dt, input longint n);
        longint unsigned a;
        longint unsigned b;
        longint decay;
        longint s;
        longint noise;
        a = exp_decay(dt);
        b = root64((64'd1 << 62) - a * a);
        decay = ((g_now - g0) * longint'(a)) >>> 31;
        s = longint'((g_sd * b) >> 31);
        noise = (s * n) >>> 12;
        return sat32(g0 + decay + noise);
    endfunction

    always @(posedge aclk) begin
        step_result_t exp_r;
        step_result_t got;
        logic [2:0]   op;
        longint unsigned dt;
        longint       v;
        longint       n;
        logic         settling;
        logic         enabled;
        logic         inj;
        longint       cur;
        if (!aresetn) begin
            rev_mv = 0;
            tau_cfg = 1000;
            g0 = 0;
            g_sd = 0;
            inject_settling = 1'b0;
            skip_negative = 1'b0;
            g_now = 0;
            g_pred = 0;
            expected_steps.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    ousnc_pkg::REG_REVERSAL_V:
                        rev_mv = longint'($signed(cfg_data[15:0]));
                    ousnc_pkg::REG_TAU_US:          tau_cfg = cfg_data[23:0];
                    ousnc_pkg::REG_G_MEAN:          g0 = longint'($signed(cfg_data));
                    ousnc_pkg::REG_G_STD:           g_sd = cfg_data[30:0];
                    ousnc_pkg::REG_ACTIVE_SETTLING: inject_settling = cfg_data[0];
                    ousnc_pkg::REG_IGNORE_NEGATIVE: skip_negative = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                op = s_tuser;
                dt = s_tdata[15:0];
                v = longint'($signed(s_tdata[31:16]));
                n = longint'($signed(s_tdata[47:32]));
                settling = s_tdata[48];
                enabled = s_tdata[49];
                inj = 1'b0;
                cur = 0;
                if (enabled) begin
                    case (op)
                        ousnc_pkg::OP_EULER: g_now = ou_advance(dt, n);
                        ousnc_pkg::OP_RK0:   g_pred = ou_advance(dt * 2, n);
                        ousnc_pkg::OP_RK1:   g_now = (g_now + g_pred) >>> 1;
                        ousnc_pkg::OP_RK3:   g_now = g_pred;
                        default: ;  // rk substep 2 and unknown codes hold
                    endcase
                    inj = (!skip_negative || g_now > 0) && (!settling || inject_settling);
                    if (inj) cur = sat32((g_now * (rev_mv - v)) >>> 6);
                end else begin
                    g_now = 0;
                end
                exp_r.conductance = g_now[31:0];
                exp_r.current_add = cur[31:0];
                exp_r.current_valid = inj;
                expected_steps = {expected_steps, exp_r};
            end
            if (m_tvalid && m_tready) begin
                got.conductance = m_tdata[31:0];
                got.current_add = m_tdata[63:32];
                got.current_valid = m_tuser[0];
                if (expected_steps.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    exp_r = expected_steps.pop_front();
                    if (got.conductance !== exp_r.conductance) begin
                        $error("conductance expected %0h got %0h",
                               exp_r.conductance, got.conductance);
                        fail_count++;
                    end
                    if (got.current_add !== exp_r.current_add) begin
                        $error("current_add expected %0h got %0h",
                               exp_r.current_add, got.current_add);
                        fail_count++;
                    end
                    if (got.current_valid !== exp_r.current_valid) begin
                        $error("current_valid expected %0b got %0b",
                               exp_r.current_valid, got.current_valid);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_steps.size();
    end

endmodule

>>> bench/ou_synaptic_noise_conductance_core_tb.sv
module ou_synaptic_noise_conductance_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // dt_us, membrane_v, gauss_sample, settling, enabled
    logic [2:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // conductance, current_add
    logic [0:0]  m_tuser;   // current_valid

    int fail_count;
    int pending;
    int results_seen;
    int idle_cycles;

    ou_synaptic_noise_conductance_core uut (.*);

    ou_synaptic_noise_conductance_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ou_synaptic_noise_conductance_core_tb: errors");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off after 200 results
    initial begin
        int gap;
        m_tready <= 1'b0;
        results_seen = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (results_seen == 200) begin
                // long stall so the core backs up and stops taking steps
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_seen++;
        end
    end

    // leaves cfg_valid high; set_regs drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // stop offering steps and wait for the core to drain before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [15:0] rev, input logic [23:0] tau,
                            input logic [31:0] mean, input logic [30:0] sd,
                            input logic act, input logic ign);
        drain();
        write_reg(ousnc_pkg::REG_REVERSAL_V, {16'd0, rev});
        write_reg(ousnc_pkg::REG_TAU_US, {8'd0, tau});
        write_reg(ousnc_pkg::REG_G_MEAN, mean);
        write_reg(ousnc_pkg::REG_G_STD, {1'b0, sd});
        write_reg(ousnc_pkg::REG_ACTIVE_SETTLING, {31'd0, act});
        write_reg(ousnc_pkg::REG_IGNORE_NEGATIVE, {31'd0, ign});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_step(input logic [2:0] op, input logic [15:0] dt,
                             input logic [15:0] v, input logic [15:0] n,
                             input logic settling, input logic enabled);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, enabled, settling, n, v, dt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'($urandom_range(0, 50));
            default: return 16'($urandom_range(0, 2000));
        endcase
    endfunction

    task automatic random_regs();
        logic [23:0] tau;
        logic [31:0] mean;
        tau  = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(1, 5000)) : 24'($urandom);
        mean = ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 1 << 24))
                                                       - 32'(1 << 23);
        set_regs(16'($urandom), tau, mean, 31'($urandom), 1'($urandom), 1'($urandom));
    endtask

    initial begin
        logic [15:0] dt;
        logic        en;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr  <= ousnc_pkg::REG_REVERSAL_V;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ousnc_pkg::OP_EULER;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset values, then field extremes with noise on
        send_step(ousnc_pkg::OP_EULER, 16'd100, 16'd0, 16'd4096, 1'b0, 1'b1);
        set_regs(16'h7fff, 24'd1000, 32'h0010_0000, 31'h0010_0000, 1'b0, 1'b0);
        send_step(ousnc_pkg::OP_EULER, 16'd0, 16'h8000, 16'h7fff, 1'b0, 1'b1);  // zero step
        send_step(ousnc_pkg::OP_EULER, 16'hffff, 16'h7fff, 16'h8000, 1'b0, 1'b1); // full decay
        send_step(ousnc_pkg::OP_RK0, 16'd300, 16'h8000, 16'h7fff, 1'b0, 1'b1);
        send_step(ousnc_pkg::OP_RK1, 16'd300, 16'd0, 16'd0, 1'b0, 1'b1);
        send_step(ousnc_pkg::OP_RK2, 16'd300, 16'd0, 16'd0, 1'b0, 1'b1);
        send_step(ousnc_pkg::OP_RK3, 16'd300, 16'd0, 16'd0, 1'b0, 1'b1);
        for (int op = 5; op <= 7; op++)                                 // unknown codes hold
            send_step(3'(op), 16'd500, 16'h1234, 16'h0800, 1'b0, 1'b1);
        send_step(ousnc_pkg::OP_EULER, 16'd50, 16'd0, 16'd0, 1'b1, 1'b1); // settling, suppressed
        send_step(ousnc_pkg::OP_EULER, 16'd50, 16'd0, 16'd0, 1'b0, 1'b0); // disabled clears
        send_step(ousnc_pkg::OP_RK3, 16'd50, 16'd0, 16'd0, 1'b0, 1'b1);   // prediction kept
        set_regs(16'h8000, 24'd0, 32'h8000_0000, 31'h7fff_ffff, 1'b1, 1'b1);  // zero tau
        send_step(ousnc_pkg::OP_EULER, 16'd1, 16'h7fff, 16'h7fff, 1'b1, 1'b1);
        send_step(ousnc_pkg::OP_EULER, 16'd0, 16'h8000, 16'h8000, 1'b1, 1'b1);
        send_step(ousnc_pkg::OP_RK0, 16'hffff, 16'h7fff, 16'h7fff, 1'b0, 1'b1);
        send_step(ousnc_pkg::OP_RK3, 16'd0, 16'h8000, 16'd0, 1'b1, 1'b1);
        set_regs(16'h7fff, 24'hffffff, 32'h7fff_ffff, 31'h7fff_ffff, 1'b1, 1'b0);
        send_step(ousnc_pkg::OP_EULER, 16'hffff, 16'h8000, 16'h7fff, 1'b0, 1'b1);
        send_step(ousnc_pkg::OP_EULER, 16'd1, 16'h8000, 16'h8000, 1'b1, 1'b1);
        send_step(ousnc_pkg::OP_RK0, 16'hffff, 16'h7fff, 16'h7fff, 1'b0, 1'b1);
        send_step(ousnc_pkg::OP_RK1, 16'hffff, 16'h8000, 16'd0, 1'b0, 1'b1);

        // random phases: mostly rk sequences and euler steps, some noise
        for (int phase = 0; phase < 8; phase++) begin
            random_regs();
            for (int i = 0; i < 120; ) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                        dt = pick_dt();
                        en = ($urandom_range(0, 19) != 0);
                        for (int op = ousnc_pkg::OP_RK0; op <= ousnc_pkg::OP_RK3; op++)
                            send_step(3'(op), dt, 16'($urandom), 16'($urandom),
                                      1'($urandom_range(0, 3) == 0), en);
                        i += 4;
                    end
                    12, 13, 14, 15, 16: begin
                        send_step(ousnc_pkg::OP_EULER, pick_dt(), 16'($urandom),
                                  16'($urandom), 1'($urandom_range(0, 3) == 0), 1'b1);
                        i++;
                    end
                    default: begin
                        send_step(3'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 1'($urandom), 1'($urandom));
                        i++;
                    end
                endcase
            end
            if (phase == 3) begin
                drain();
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("ou_synaptic_noise_conductance_core_tb: clean");
        else
            $display("ou_synaptic_noise_conductance_core_tb: errors");
        $finish;
    end

endmodule

>>> ou_synaptic_noise_conductance_core.f
rtl/ousnc_pkg.sv
rtl/ousnc_mul.sv
rtl/ousnc_div.sv
rtl/ousnc_sqrt.sv
rtl/ou_synaptic_noise_conductance_core.sv
bench/ou_synaptic_noise_conductance_checker.sv
bench/ou_synaptic_noise_conductance_core_tb.sv
